// File: hdl/crc16_packet_deframer_defines.svh
// Assertion macros shared by the deframer RTL.
`ifndef CRC16_PACKET_DEFRAMER_DEFINES_SVH
`define CRC16_PACKET_DEFRAMER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define CRCDF_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("crc16_packet_deframer: assertion failed");
`define CRCDF_NEVER(label, expr) `CRCDF_ASSERT(label, !(expr))
`else
`define CRCDF_ASSERT(label, prop)
`define CRCDF_NEVER(label, expr)
`endif
`endif

// File: hdl/crcdf_pkg.sv
// Types and constants of the CRC-16 packet deframer.
`default_nettype none
package crcdf_pkg;
	localparam int MAX_PAYLOAD = 32;
	localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
	localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

	typedef logic [7:0] byte_t;
	typedef logic [5:0] plen_t;
	typedef logic [4:0] bidx_t;
	typedef logic [15:0] crc_t;
	typedef logic [LEN_W-1:0] len_t;
	typedef logic [ADDR_W-1:0] addr_t;

	localparam crc_t CRC_INIT = 16'hFFFF;
	localparam crc_t CRC_POLY = 16'h1021;
	localparam byte_t HDR_FIRST_RESET = 8'hAA;
	localparam byte_t HDR_SECOND_RESET = 8'h55;

	localparam logic REG_HDR_FIRST = 1'b0;
	localparam logic REG_HDR_SECOND = 1'b1;
endpackage
`default_nettype wire

// File: hdl/crcdf_in_if.sv
// Input channel carrying one received byte per word.
`default_nettype none
interface crcdf_in_if;
	logic valid;
	logic ready;
	crcdf_pkg::byte_t rx_byte;
	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

// File: hdl/crcdf_out_if.sv
// Output channel carrying one packet payload byte per word.
`default_nettype none
interface crcdf_out_if;
	logic valid;
	logic ready;
	crcdf_pkg::byte_t msg_id;
	crcdf_pkg::plen_t payload_len;
	logic has_data;
	crcdf_pkg::byte_t payload_byte;
	crcdf_pkg::bidx_t byte_index;
	logic last;
	modport source (output valid, output msg_id, output payload_len, output has_data,
		output payload_byte, output byte_index, output last, input ready);
	modport sink (input valid, input msg_id, input payload_len, input has_data,
		input payload_byte, input byte_index, input last, output ready);
endinterface
`default_nettype wire

// File: hdl/crc16_packet_deframer.sv
// Receive-side packet deframer with CRC-16/CCITT-FALSE check.
// The block takes one byte per word and hunts for the two header bytes set in its
// registers, then reads a message id, a length byte, the payload and a little-endian
// CRC. A byte that enters the CRC (second header byte, id, length, payload) keeps the
// input stalled after acceptance while a bit-serial CRC unit folds it in; for the
// second header byte the first is folded as well. Any other byte is taken without that
// stall. A matching packet is sent from the payload RAM one word at a time, the next
// fetched once the last is accepted; an empty one sends a word without data, and a
// mismatch is dropped. No input is taken while a packet is being sent.
`default_nettype none
`include "crc16_packet_deframer_defines.svh"
module crc16_packet_deframer (
	input wire logic clk,
	input wire logic arst_n,
	crcdf_in_if.sink rx,
	crcdf_out_if.source tx,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [2:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	typedef enum logic [6:0] {
		PH_HDR1 = 7'b0000001,
		PH_HDR2 = 7'b0000010,
		PH_ID   = 7'b0000100,
		PH_LEN  = 7'b0001000,
		PH_DATA = 7'b0010000,
		PH_CRCL = 7'b0100000,
		PH_CRCH = 7'b1000000
	} phase_t;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_CRC   = 5'b00010,
		S_FETCH = 5'b00100,
		S_LOAD  = 5'b01000,
		S_HOLD  = 5'b10000
	} state_t;

	state_t state_q;
	phase_t phase_q;
	crcdf_pkg::byte_t hdr_first_q;
	crcdf_pkg::byte_t hdr_second_q;
	crcdf_pkg::crc_t crc_q;
	crcdf_pkg::byte_t shift_q;
	crcdf_pkg::byte_t next_q;
	logic pend_q;
	logic [2:0] bit_cnt_q;
	crcdf_pkg::byte_t msg_id_q;
	crcdf_pkg::len_t len_q;
	crcdf_pkg::len_t fill_q;
	crcdf_pkg::byte_t rcv_lo_q;
	crcdf_pkg::addr_t idx_q;
	logic out_valid_q;
	logic out_has_q;
	crcdf_pkg::byte_t out_byte_q;
	crcdf_pkg::bidx_t out_idx_q;
	logic out_last_q;

	logic rx_acc;
	logic tx_acc;
	logic cfg_wr;
	logic cfg_idx;
	crcdf_pkg::byte_t b;
	crcdf_pkg::len_t fill_next;
	logic fb;
	crcdf_pkg::crc_t crc_next;
	logic ram_we;
	crcdf_pkg::byte_t ram_rdata;

	assign rx.ready = (state_q == S_IDLE);
	assign rx_acc = rx.valid && rx.ready;
	assign tx_acc = tx.valid && tx.ready;
	assign b = rx.rx_byte;
	assign fill_next = fill_q + crcdf_pkg::len_t'(1);

	assign cfg_wr = psel && penable && pwrite && pready;
	assign cfg_idx = paddr[2];
	assign pready = 1'b1;

	always_comb begin
		unique case (cfg_idx)
			crcdf_pkg::REG_HDR_FIRST: prdata = {24'b0, hdr_first_q};
			crcdf_pkg::REG_HDR_SECOND: prdata = {24'b0, hdr_second_q};
			default: prdata = '0;
		endcase
	end

	assign fb = crc_q[15] ^ shift_q[7];
	assign crc_next = {crc_q[14:0], 1'b0} ^ (fb ? crcdf_pkg::CRC_POLY : '0);

	assign ram_we = rx_acc && (phase_q == PH_DATA);

	crcdf_ram #(
		.WIDTH(8),
		.DEPTH(crcdf_pkg::MAX_PAYLOAD)
	) u_store (
		.clk(clk),
		.we(ram_we),
		.waddr(crcdf_pkg::addr_t'(fill_q)),
		.wdata(b),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	assign tx.valid = out_valid_q;
	assign tx.msg_id = msg_id_q;
	assign tx.payload_len = crcdf_pkg::plen_t'(len_q);
	assign tx.has_data = out_has_q;
	assign tx.payload_byte = out_byte_q;
	assign tx.byte_index = out_idx_q;
	assign tx.last = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_first_q <= crcdf_pkg::HDR_FIRST_RESET;
			hdr_second_q <= crcdf_pkg::HDR_SECOND_RESET;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				crcdf_pkg::REG_HDR_FIRST: hdr_first_q <= pwdata[7:0];
				crcdf_pkg::REG_HDR_SECOND: hdr_second_q <= pwdata[7:0];
				default: hdr_first_q <= hdr_first_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= PH_HDR1;
			crc_q <= crcdf_pkg::CRC_INIT;
			shift_q <= '0;
			next_q <= '0;
			pend_q <= 1'b0;
			bit_cnt_q <= '0;
			msg_id_q <= '0;
			len_q <= '0;
			fill_q <= '0;
			rcv_lo_q <= '0;
			idx_q <= '0;
			out_valid_q <= 1'b0;
			out_has_q <= 1'b0;
			out_byte_q <= '0;
			out_idx_q <= '0;
			out_last_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (rx_acc) begin
						unique case (phase_q)
							PH_HDR1: begin
								if (b == hdr_first_q) begin
									phase_q <= PH_HDR2;
								end
							end
							PH_HDR2: begin
								if (b == hdr_second_q) begin
									crc_q <= crcdf_pkg::CRC_INIT;
									shift_q <= hdr_first_q;
									next_q <= b;
									pend_q <= 1'b1;
									bit_cnt_q <= '0;
									state_q <= S_CRC;
									phase_q <= PH_ID;
								end else if (b == hdr_first_q) begin
									phase_q <= PH_HDR2;
								end else begin
									phase_q <= PH_HDR1;
								end
							end
							PH_ID: begin
								msg_id_q <= b;
								shift_q <= b;
								pend_q <= 1'b0;
								bit_cnt_q <= '0;
								state_q <= S_CRC;
								phase_q <= PH_LEN;
							end
							PH_LEN: begin
								if (b > crcdf_pkg::byte_t'(crcdf_pkg::MAX_PAYLOAD)) begin
									phase_q <= (b == hdr_first_q) ? PH_HDR2 : PH_HDR1;
								end else begin
									len_q <= crcdf_pkg::len_t'(b);
									shift_q <= b;
									pend_q <= 1'b0;
									bit_cnt_q <= '0;
									fill_q <= '0;
									state_q <= S_CRC;
									phase_q <= (b == '0) ? PH_CRCL : PH_DATA;
								end
							end
							PH_DATA: begin
								shift_q <= b;
								pend_q <= 1'b0;
								bit_cnt_q <= '0;
								fill_q <= fill_next;
								state_q <= S_CRC;
								if (fill_next >= len_q) begin
									phase_q <= PH_CRCL;
								end
							end
							PH_CRCL: begin
								rcv_lo_q <= b;
								phase_q <= PH_CRCH;
							end
							PH_CRCH: begin
								phase_q <= PH_HDR1;
								if ({b, rcv_lo_q} == crc_q) begin
									if (len_q == '0) begin
										out_has_q <= 1'b0;
										out_byte_q <= '0;
										out_idx_q <= '0;
										out_last_q <= 1'b1;
										out_valid_q <= 1'b1;
										state_q <= S_HOLD;
									end else begin
										idx_q <= '0;
										state_q <= S_FETCH;
									end
								end
							end
							default: phase_q <= PH_HDR1;
						endcase
					end
				end
				S_CRC: begin
					crc_q <= crc_next;
					bit_cnt_q <= bit_cnt_q + 3'd1;
					if (bit_cnt_q == 3'd7 && pend_q) begin
						shift_q <= next_q;
						pend_q <= 1'b0;
					end else begin
						shift_q <= {shift_q[6:0], 1'b0};
						if (bit_cnt_q == 3'd7) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_FETCH: state_q <= S_LOAD;
				S_LOAD: begin
					out_has_q <= 1'b1;
					out_byte_q <= ram_rdata;
					out_idx_q <= crcdf_pkg::bidx_t'(idx_q);
					out_last_q <= ((crcdf_pkg::len_t'(idx_q) + crcdf_pkg::len_t'(1)) == len_q);
					out_valid_q <= 1'b1;
					state_q <= S_HOLD;
				end
				S_HOLD: begin
					if (tx_acc) begin
						out_valid_q <= 1'b0;
						if (out_last_q) begin
							state_q <= S_IDLE;
						end else begin
							idx_q <= idx_q + crcdf_pkg::addr_t'(1);
							state_q <= S_FETCH;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`CRCDF_NEVER(a_no_input_while_sending, rx.ready && out_valid_q)
	`CRCDF_ASSERT(a_id_enters_crc, (rx_acc && (phase_q == PH_ID)) |=> (state_q == S_CRC))
	`CRCDF_ASSERT(a_last_ends_packet, (tx_acc && out_last_q) |=> (state_q == S_IDLE))
	`CRCDF_ASSERT(a_store_in_range, ram_we |-> (fill_q < len_q))
	`CRCDF_ASSERT(a_index_in_packet, (out_valid_q && out_has_q) |-> (crcdf_pkg::len_t'(out_idx_q) < len_q))
endmodule
`default_nettype wire

// File: hdl/crcdf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module crcdf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire
